/* rtl/core/mm4_pkg.sv */
package mm4_pkg;

  // Matrix order is tied to the 2-bit row/col fields.
  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  // Exact sum of DIM products.
  localparam int unsigned ACC_W     = PROD_W + $clog2(DIM);
  // Term counter runs 0..DIM (one extra step drains the product register).
  localparam int unsigned CNT_W     = $clog2(DIM + 1);

  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_MUL_EMIT   = 2'd2,
    OP_MUL_LEFT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RES,
    ST_COPY
  } state_e;

  typedef struct packed {
    op_e                     operation;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } resp_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

  typedef struct packed {
    logic out_load;
    logic row_wr;
    logic copy;
  } seq_ctl_t;

endpackage

/* rtl/core/matrix4x4_multiply_top.sv */
// 4x4 matrix multiplier, signed Q16.16 elements.
//
// Request channel (in_valid_i / in_ready_o / in_req_i):
//   load left / load right write one element; loads may follow each other
//   every cycle while no product is in progress.
//   multiply-and-emit and multiply-into-left start a product; in_ready_o
//   stays low until the whole product is done.
// Result channel (out_valid_o / out_ready_i / out_resp_o): multiply-and-emit
//   gives sixteen results in row-major order, last set on the final one.
//   Multiply-into-left gives none.
// Schedule: each element runs on the one shared 32x32 multiplier as DIM
//   term steps, one drain step and one round/saturate step. An in-place
//   multiply adds one row copy step per row.
// The result register lets the next element be computed while a result
//   waits; if the receiver stalls, the sequencer holds before loading the
//   next result, so nothing is dropped. The last result may still wait
//   while new loads are taken.
// Reset clears both matrices to zero and empties the result register.
module matrix4x4_multiply_top #(
  parameter int unsigned FracBits = mm4_pkg::FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mm4_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mm4_pkg::resp_t out_resp_o
);

  localparam int unsigned Dim  = mm4_pkg::DIM;
  localparam int unsigned IdxW = mm4_pkg::IDX_W;
  localparam int unsigned ValW = mm4_pkg::VAL_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Dim - 1);

  // Element stores, row-major, cleared by reset.
  logic signed [ValW-1:0] left_q  [Dim][Dim];
  logic signed [ValW-1:0] right_q [Dim][Dim];
  // One product row, held until the left row may be overwritten.
  logic signed [ValW-1:0] rowbuf_q [Dim];

  logic                   in_fire;
  logic                   out_free;
  logic                   out_valid_q;
  mm4_pkg::resp_t         out_q;

  mm4_pkg::mac_ctl_t      mac_ctl;
  mm4_pkg::seq_ctl_t      seq_ctl;
  logic [IdxW-1:0]        row;
  logic [IdxW-1:0]        col;
  logic [IdxW-1:0]        term;
  logic signed [ValW-1:0] opnd_a;
  logic signed [ValW-1:0] opnd_b;
  logic signed [ValW-1:0] elem;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  mm4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .op_i       (in_req_i.operation),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .mac_ctl_o  (mac_ctl),
    .seq_ctl_o  (seq_ctl),
    .row_o      (row),
    .col_o      (col),
    .term_o     (term)
  );

  assign opnd_a = left_q[row][term];
  assign opnd_b = right_q[term][col];

  mm4_mac #(
    .FracBits (FracBits)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (opnd_a),
    .b_i   (opnd_b),
    .res_o (elem)
  );

  // Row/col fields are exactly as wide as the index, so every load is in range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          left_q[r][c]  <= '0;
          right_q[r][c] <= '0;
        end
      end
    end else begin
      if (in_fire && in_req_i.operation == mm4_pkg::OP_LOAD_LEFT) begin
        left_q[in_req_i.row][in_req_i.col] <= in_req_i.value;
      end
      if (in_fire && in_req_i.operation == mm4_pkg::OP_LOAD_RIGHT) begin
        right_q[in_req_i.row][in_req_i.col] <= in_req_i.value;
      end
      if (seq_ctl.copy) begin
        for (int c = 0; c < Dim; c++) begin
          left_q[row][c] <= rowbuf_q[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ctl.row_wr) begin
      rowbuf_q[col] <= elem;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ctl.out_load) begin
      out_q.out_row   <= row;
      out_q.out_col   <= col;
      out_q.out_value <= elem;
      out_q.last      <= (row == LastIdx) && (col == LastIdx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_q;

endmodule

/* rtl/core/mm4_mac.sv */
// Shared multiply-accumulate unit: one 32x32 multiplier, registered product,
// exact accumulator, then floor shift and saturation.
module mm4_mac #(
  parameter int unsigned FracBits = mm4_pkg::FRAC_BITS
) (
  input  logic                              clk_i,
  input  mm4_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [mm4_pkg::VAL_W-1:0]  a_i,
  input  logic signed [mm4_pkg::VAL_W-1:0]  b_i,
  output logic signed [mm4_pkg::VAL_W-1:0]  res_o
);

  localparam int unsigned ValW  = mm4_pkg::VAL_W;
  localparam int unsigned ProdW = mm4_pkg::PROD_W;
  localparam int unsigned AccW  = mm4_pkg::ACC_W;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  shifted;
  logic [AccW-ValW:0]      upper;
  logic                    fits;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  // Arithmetic shift of the exact sum rounds toward minus infinity.
  assign shifted = acc_q >>> FracBits;
  assign upper   = shifted[AccW-1:ValW-1];
  assign fits    = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      res_o = shifted[ValW-1:0];
    end else if (shifted[AccW-1]) begin
      res_o = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(ValW-1){1'b1}}};
    end
  end

endmodule

/* rtl/core/mm4_seq.sv */
// Sequencer: walks row, column and term indices over the shared MAC.
module mm4_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  mm4_pkg::op_e                  op_i,
  input  logic                          out_free_i,
  output logic                          in_ready_o,
  output mm4_pkg::mac_ctl_t             mac_ctl_o,
  output mm4_pkg::seq_ctl_t             seq_ctl_o,
  output logic [mm4_pkg::IDX_W-1:0]     row_o,
  output logic [mm4_pkg::IDX_W-1:0]     col_o,
  output logic [mm4_pkg::IDX_W-1:0]     term_o
);

  localparam int unsigned IdxW = mm4_pkg::IDX_W;
  localparam int unsigned CntW = mm4_pkg::CNT_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(mm4_pkg::DIM - 1);
  localparam logic [CntW-1:0] NumTerms = CntW'(mm4_pkg::DIM);

  mm4_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  row_q, row_d;
  logic [IdxW-1:0]  col_q, col_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm4_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    emit_d     = emit_q;
    in_ready_o = 1'b0;
    mac_ctl_o  = '0;
    seq_ctl_o  = '0;

    unique case (state_q)
      mm4_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i && (op_i == mm4_pkg::OP_MUL_EMIT ||
                          op_i == mm4_pkg::OP_MUL_LEFT)) begin
          emit_d  = (op_i == mm4_pkg::OP_MUL_EMIT);
          row_d   = '0;
          col_d   = '0;
          k_d     = '0;
          state_d = mm4_pkg::ST_MAC;
        end
      end

      mm4_pkg::ST_MAC: begin
        mac_ctl_o.clear  = (k_q == '0);
        mac_ctl_o.mul_en = (k_q < NumTerms);
        mac_ctl_o.acc_en = (k_q != '0);
        k_d              = k_q + CntW'(1);
        if (k_q == NumTerms) begin
          state_d = mm4_pkg::ST_RES;
        end
      end

      mm4_pkg::ST_RES: begin
        if (emit_q) begin
          if (out_free_i) begin
            seq_ctl_o.out_load = 1'b1;
            k_d                = '0;
            state_d            = mm4_pkg::ST_MAC;
            if (col_q == LastIdx) begin
              col_d = '0;
              if (row_q == LastIdx) begin
                state_d = mm4_pkg::ST_IDLE;
              end else begin
                row_d = row_q + IdxW'(1);
              end
            end else begin
              col_d = col_q + IdxW'(1);
            end
          end
        end else begin
          seq_ctl_o.row_wr = 1'b1;
          k_d              = '0;
          if (col_q == LastIdx) begin
            state_d = mm4_pkg::ST_COPY;
          end else begin
            col_d   = col_q + IdxW'(1);
            state_d = mm4_pkg::ST_MAC;
          end
        end
      end

      mm4_pkg::ST_COPY: begin
        // Row of the product replaces the left row; later rows never read it.
        seq_ctl_o.copy = 1'b1;
        col_d          = '0;
        k_d            = '0;
        if (row_q == LastIdx) begin
          state_d = mm4_pkg::ST_IDLE;
        end else begin
          row_d   = row_q + IdxW'(1);
          state_d = mm4_pkg::ST_MAC;
        end
      end

      default: begin
        state_d = mm4_pkg::ST_IDLE;
      end
    endcase
  end

  assign row_o  = row_q;
  assign col_o  = col_q;
  assign term_o = k_q[IdxW-1:0];

endmodule

/* rtl/core/mm4_chk.sv */
module mm4_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input mm4_pkg::req_t  in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mm4_pkg::resp_t out_resp_o
);

  localparam logic [mm4_pkg::IDX_W-1:0] LastIdx = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);

  // The last flag only ever marks the bottom-right element.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_resp_o.last |->
      out_resp_o.out_row == LastIdx && out_resp_o.out_col == LastIdx)
    else $error("last flag on wrong element");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_resp_o))
    else $error("stalled result changed");

  // Only a multiply request makes the block busy.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |->
      $past(in_valid_i) &&
      ($past(in_req_i.operation) == mm4_pkg::OP_MUL_EMIT ||
       $past(in_req_i.operation) == mm4_pkg::OP_MUL_LEFT))
    else $error("ready dropped without a multiply request");

  // A load request never leaves the block busy.
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
      (in_req_i.operation == mm4_pkg::OP_LOAD_LEFT ||
       in_req_i.operation == mm4_pkg::OP_LOAD_RIGHT) |=> in_ready_o)
    else $error("load request left the block busy");

endmodule

bind matrix4x4_multiply_top mm4_chk u_mm4_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_resp_o  (out_resp_o)
);
